// ===== design/rv32i_subset_execute_defines.svh =====
// Assertion macros shared by the execute block's modules.
`ifndef RV32I_SUBSET_EXECUTE_DEFINES_SVH
`define RV32I_SUBSET_EXECUTE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RVX_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RVX_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rvx_pkg.sv =====
// Types, opcodes and status codes of the RV32I subset execute block.
package rvx_pkg;

	localparam int unsigned REG_COUNT = 32;
	localparam int unsigned RF_AW = 5;
	localparam int unsigned MEM_ADDR_W = 10;
	localparam logic [16:0] PLEN_RESET = 17'd1024;

	localparam logic [6:0] OPC_LOAD = 7'b0000011;
	localparam logic [6:0] OPC_STORE = 7'b0100011;
	localparam logic [6:0] OPC_RTYPE = 7'b0110011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_ITYPE = 7'b0010011;

	localparam logic [2:0] F3_ADD = 3'b000;
	localparam logic [2:0] F3_AND = 3'b111;
	localparam logic [2:0] F3_OR = 3'b110;
	localparam logic [2:0] F3_WORD = 3'b010;
	localparam logic [2:0] F3_BEQ = 3'b000;

	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT = 7'b0100000;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_BAD_TARGET = 2'd2;
	localparam logic [1:0] ST_BAD_ADDR = 2'd3;

	typedef struct packed {
		logic [15:0] next_pc;
		logic taken;
		logic reg_we;
		logic [RF_AW-1:0] rd;
		logic [31:0] result;
		logic mem_rd;
		logic mem_we;
		logic [MEM_ADDR_W-1:0] mem_address;
		logic [31:0] mem_wdata;
		logic [1:0] status;
	} exec_res_t;

endpackage

// ===== design/rv32i_subset_execute.sv =====
// Top level of the RV32I subset execute block: pipeline control, forwarding, config.
//
//   Channel   Signals                         Direction  Handshake
//   in        instruction                     to block   in_valid / in_ready
//   out       next_pc ... status (9 fields)   from block out_valid / out_ready
//   cfg       cfg_wr_data (program_length)    to block   cfg_wr_en, no wait
//
// One word can enter every cycle while in_ready is high; it passes three registered stages in order:
// register file read, execute with data memory access, then write-back into the output register.
// Loads set the depth, since their data comes from the synchronous data memory. After reset the
// data memory is zeroed with in_ready held low. While the output register is held, words still
// move on into empty stages, and in_ready drops in the same cycle once all three stages hold a word.
`include "rv32i_subset_execute_defines.svh"

module rv32i_subset_execute #(
	parameter int unsigned DATA_WORDS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] instruction,
	output logic out_valid,
	input logic out_ready,
	output logic [15:0] next_pc,
	output logic branch_taken,
	output logic reg_write_enable,
	output logic [4:0] reg_write_index,
	output logic signed [31:0] reg_write_data,
	output logic mem_write_enable,
	output logic [9:0] mem_address,
	output logic signed [31:0] mem_write_data,
	output logic [1:0] status,
	input logic cfg_wr_en,
	input logic [16:0] cfg_wr_data
);

	localparam int unsigned AW = $clog2(DATA_WORDS);

	logic [16:0] program_length_q;
	logic [15:0] pc_q;

	logic in_fire;
	logic s1_fire;
	logic s2_fire;
	logic s2_free;
	logic adv_out;
	logic dmem_busy;

	logic s1_v_q;
	logic [31:0] ins_s1;
	logic [4:0] rs1_s1;
	logic [4:0] rs2_s1;
	logic ovr_a_v_q;
	logic ovr_b_v_q;
	logic [31:0] ovr_a_q;
	logic [31:0] ovr_b_q;
	logic [31:0] rf_rdata_a;
	logic [31:0] rf_rdata_b;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] access_addr;
	rvx_pkg::exec_res_t ex;

	logic s2_v_q;
	rvx_pkg::exec_res_t res_s2;
	logic [31:0] dmem_rdata;
	logic [31:0] wb_data;
	logic wb_we;

	logic out_valid_q;
	rvx_pkg::exec_res_t out_res_q;
	logic [31:0] out_wdata_q;

	assign adv_out = !out_valid_q || out_ready;
	assign s2_fire = s2_v_q && adv_out;
	assign s2_free = !s2_v_q || adv_out;
	assign s1_fire = s1_v_q && s2_free;
	assign in_ready = !dmem_busy && (!s1_v_q || s2_free);
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_length_q <= rvx_pkg::PLEN_RESET;
		end else if (cfg_wr_en) begin
			program_length_q <= cfg_wr_data;
		end
	end

	rvx_regfile u_regfile (
		.clk(clk),
		.arst_n(arst_n),
		.re(in_fire),
		.raddr_a(instruction[19:15]),
		.raddr_b(instruction[24:20]),
		.we(wb_we),
		.waddr(res_s2.rd),
		.wdata(wb_data),
		.rdata_a(rf_rdata_a),
		.rdata_b(rf_rdata_b)
	);

	assign rs1_s1 = ins_s1[19:15];
	assign rs2_s1 = ins_s1[24:20];

	// Write-backs that land after the register read are caught here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			ovr_a_v_q <= 1'b0;
			ovr_b_v_q <= 1'b0;
		end else begin
			if (!s1_v_q || s2_free) begin
				s1_v_q <= in_fire;
			end
			if (in_fire) begin
				ovr_a_v_q <= wb_we && (res_s2.rd == instruction[19:15]);
				ovr_b_v_q <= wb_we && (res_s2.rd == instruction[24:20]);
			end else begin
				if (wb_we && (res_s2.rd == rs1_s1)) begin
					ovr_a_v_q <= 1'b1;
				end
				if (wb_we && (res_s2.rd == rs2_s1)) begin
					ovr_b_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ins_s1 <= instruction;
		end
		if (wb_we && (in_fire ? (res_s2.rd == instruction[19:15]) : (res_s2.rd == rs1_s1))) begin
			ovr_a_q <= wb_data;
		end
		if (wb_we && (in_fire ? (res_s2.rd == instruction[24:20]) : (res_s2.rd == rs2_s1))) begin
			ovr_b_q <= wb_data;
		end
	end

	always_comb begin
		if (s2_v_q && res_s2.reg_we && (res_s2.rd == rs1_s1)) begin
			op_a = wb_data;
		end else if (ovr_a_v_q) begin
			op_a = ovr_a_q;
		end else begin
			op_a = rf_rdata_a;
		end
		if (s2_v_q && res_s2.reg_we && (res_s2.rd == rs2_s1)) begin
			op_b = wb_data;
		end else if (ovr_b_v_q) begin
			op_b = ovr_b_q;
		end else begin
			op_b = rf_rdata_b;
		end
	end

	rvx_exec #(
		.DATA_WORDS(DATA_WORDS)
	) u_exec (
		.instruction(ins_s1),
		.op_a(op_a),
		.op_b(op_b),
		.pc(pc_q),
		.program_length(program_length_q),
		.access_addr(access_addr),
		.res(ex)
	);

	rvx_dmem #(
		.DATA_WORDS(DATA_WORDS)
	) u_dmem (
		.clk(clk),
		.arst_n(arst_n),
		.re(s1_fire && ex.mem_rd),
		.we(s1_fire && ex.mem_we),
		.addr(access_addr[AW-1:0]),
		.wdata(ex.mem_wdata),
		.rdata(dmem_rdata),
		.busy(dmem_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			s2_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				pc_q <= ex.next_pc;
			end
			if (s2_free) begin
				s2_v_q <= s1_fire;
			end
			if (adv_out) begin
				out_valid_q <= s2_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_s2 <= ex;
		end
		if (s2_fire) begin
			out_res_q <= res_s2;
			out_wdata_q <= res_s2.reg_we ? wb_data : 32'd0;
		end
	end

	assign wb_data = res_s2.mem_rd ? dmem_rdata : res_s2.result;
	assign wb_we = s2_fire && res_s2.reg_we;

	assign out_valid = out_valid_q;
	assign next_pc = out_res_q.next_pc;
	assign branch_taken = out_res_q.taken;
	assign reg_write_enable = out_res_q.reg_we;
	assign reg_write_index = out_res_q.rd;
	assign reg_write_data = $signed(out_wdata_q);
	assign mem_write_enable = out_res_q.mem_we;
	assign mem_address = out_res_q.mem_address;
	assign mem_write_data = $signed(out_res_q.mem_wdata);
	assign status = out_res_q.status;

	`RVX_ASSERT_NOW(a_no_x0_write, clk, arst_n, wb_we, res_s2.rd != 5'd0, "Write-back to x0.")
	`RVX_ASSERT_NOW(a_err_no_side_effect, clk, arst_n, out_valid_q && (out_res_q.status != rvx_pkg::ST_OK), !out_res_q.reg_we && !out_res_q.mem_we, "Failed word has side effects.")
	`RVX_ASSERT_NEXT(a_branch_in_range, clk, arst_n, s1_fire && ex.taken, {1'b0, pc_q} < program_length_q, "Taken branch left program range.")

endmodule

// ===== design/rvx_regfile.sv =====
// Register file: two registered read ports, one write port, per-entry valid bits.
`include "rv32i_subset_execute_defines.svh"

module rvx_regfile (
	input logic clk,
	input logic arst_n,
	input logic re,
	input logic [rvx_pkg::RF_AW-1:0] raddr_a,
	input logic [rvx_pkg::RF_AW-1:0] raddr_b,
	input logic we,
	input logic [rvx_pkg::RF_AW-1:0] waddr,
	input logic [31:0] wdata,
	output logic [31:0] rdata_a,
	output logic [31:0] rdata_b
);

	logic [31:0] mem [rvx_pkg::REG_COUNT];
	logic [rvx_pkg::REG_COUNT-1:0] valid_q;
	logic [31:0] data_a_q;
	logic [31:0] data_b_q;
	logic valid_a_q;
	logic valid_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			data_a_q <= mem[raddr_a];
			data_b_q <= mem[raddr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			valid_a_q <= 1'b0;
			valid_b_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				valid_a_q <= valid_q[raddr_a];
				valid_b_q <= valid_q[raddr_b];
			end
		end
	end

	assign rdata_a = valid_a_q ? data_a_q : 32'd0;
	assign rdata_b = valid_b_q ? data_b_q : 32'd0;

	`RVX_ASSERT_NEXT(a_rf_valid_set, clk, arst_n, we, valid_q[$past(waddr)], "Written entry not marked valid.")

endmodule

// ===== design/rvx_dmem.sv =====
// Data memory with a zeroing sweep after reset and a registered read port.
`include "rv32i_subset_execute_defines.svh"

module rvx_dmem #(
	parameter int unsigned DATA_WORDS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic re,
	input logic we,
	input logic [$clog2(DATA_WORDS)-1:0] addr,
	input logic [31:0] wdata,
	output logic [31:0] rdata,
	output logic busy
);

	localparam int unsigned AW = $clog2(DATA_WORDS);
	localparam logic [AW-1:0] LAST = AW'(DATA_WORDS - 1);

	logic [31:0] mem [DATA_WORDS];
	logic [31:0] rdata_q;
	logic clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= 32'd0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign rdata = rdata_q;
	assign busy = clr_busy_q;

	`RVX_ASSERT_NOW(a_dmem_no_access_in_clear, clk, arst_n, we || re, !clr_busy_q, "Access during clear.")

endmodule

// ===== design/rvx_exec.sv =====
// Decode and execute of one instruction word: ALU, address check, branch resolution.
module rvx_exec #(
	parameter int unsigned DATA_WORDS = 1024
) (
	input logic [31:0] instruction,
	input logic [31:0] op_a,
	input logic [31:0] op_b,
	input logic [15:0] pc,
	input logic [16:0] program_length,
	output logic [31:0] access_addr,
	output rvx_pkg::exec_res_t res
);

	localparam logic [31:0] DW32 = 32'(DATA_WORDS);

	logic [6:0] opc;
	logic [4:0] rd;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] addr_sum;
	logic addr_ok;
	logic signed [12:0] bimm;
	logic signed [12:0] brounded;
	logic [10:0] off;
	logic [17:0] tgt;
	logic tgt_ok;
	logic [15:0] next_seq;
	logic wr;
	logic [31:0] val;

	assign opc = instruction[6:0];
	assign rd = instruction[11:7];
	assign f3 = instruction[14:12];
	assign f7 = instruction[31:25];
	assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
	assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
	assign addr_sum = op_a + ((opc == rvx_pkg::OPC_STORE) ? imm_s : imm_i);
	assign addr_ok = addr_sum < DW32;
	assign access_addr = addr_sum;

	// The branch offset is the byte offset divided by four, rounded toward zero.
	assign bimm = {instruction[31], instruction[7], instruction[30:25],
		instruction[11:8], 1'b0};
	assign brounded = bimm[12] ? (bimm + 13'sd3) : bimm;
	assign off = brounded[12:2];
	assign tgt = {2'b00, pc} + {{7{off[10]}}, off};
	assign tgt_ok = !tgt[17] && !tgt[16] && ({1'b0, tgt[15:0]} < program_length);
	assign next_seq = pc + 16'd1;

	always_comb begin
		res = '0;
		res.next_pc = next_seq;
		res.status = rvx_pkg::ST_OK;
		wr = 1'b0;
		val = 32'd0;
		case (opc)
			rvx_pkg::OPC_RTYPE: begin
				if (f7 == rvx_pkg::F7_BASE && f3 == rvx_pkg::F3_ADD) begin
					val = op_a + op_b;
					wr = 1'b1;
				end else if (f7 == rvx_pkg::F7_ALT && f3 == rvx_pkg::F3_ADD) begin
					val = op_a - op_b;
					wr = 1'b1;
				end else if (f7 == rvx_pkg::F7_BASE && f3 == rvx_pkg::F3_AND) begin
					val = op_a & op_b;
					wr = 1'b1;
				end else if (f7 == rvx_pkg::F7_BASE && f3 == rvx_pkg::F3_OR) begin
					val = op_a | op_b;
					wr = 1'b1;
				end else begin
					res.status = rvx_pkg::ST_UNSUPPORTED;
				end
			end
			rvx_pkg::OPC_ITYPE: begin
				if (f3 == rvx_pkg::F3_ADD) begin
					val = op_a + imm_i;
					wr = 1'b1;
				end else if (f3 == rvx_pkg::F3_AND) begin
					val = op_a & imm_i;
					wr = 1'b1;
				end else if (f3 == rvx_pkg::F3_OR) begin
					val = op_a | imm_i;
					wr = 1'b1;
				end else begin
					res.status = rvx_pkg::ST_UNSUPPORTED;
				end
			end
			rvx_pkg::OPC_LOAD: begin
				if (f3 != rvx_pkg::F3_WORD) begin
					res.status = rvx_pkg::ST_UNSUPPORTED;
				end else if (!addr_ok) begin
					res.status = rvx_pkg::ST_BAD_ADDR;
				end else begin
					wr = 1'b1;
					res.mem_rd = 1'b1;
					res.mem_address = addr_sum[rvx_pkg::MEM_ADDR_W-1:0];
				end
			end
			rvx_pkg::OPC_STORE: begin
				if (f3 != rvx_pkg::F3_WORD) begin
					res.status = rvx_pkg::ST_UNSUPPORTED;
				end else if (!addr_ok) begin
					res.status = rvx_pkg::ST_BAD_ADDR;
				end else begin
					res.mem_we = 1'b1;
					res.mem_wdata = op_b;
					res.mem_address = addr_sum[rvx_pkg::MEM_ADDR_W-1:0];
				end
			end
			rvx_pkg::OPC_BRANCH: begin
				if (f3 != rvx_pkg::F3_BEQ) begin
					res.status = rvx_pkg::ST_UNSUPPORTED;
				end else if (op_a == op_b) begin
					if (tgt_ok) begin
						res.taken = 1'b1;
						res.next_pc = tgt[15:0];
					end else begin
						res.status = rvx_pkg::ST_BAD_TARGET;
					end
				end
			end
			default: begin
				res.status = rvx_pkg::ST_UNSUPPORTED;
			end
		endcase
		res.reg_we = wr && (rd != 5'd0);
		res.rd = res.reg_we ? rd : 5'd0;
		res.result = res.reg_we ? val : 32'd0;
	end

endmodule
